>>> hw/rtl/ndg_pkg.sv
// Shared types, register indexes and the luma function for the
// nearest-neighbor gray downscaler. No dependencies.
package ndg_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_SRC_W = 4'd0;
    localparam logic [3:0] CFG_SRC_H = 4'd1;
    localparam logic [3:0] CFG_DST_W = 4'd2;
    localparam logic [3:0] CFG_DST_H = 4'd3;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 11;

    // Reset values of the size registers
    localparam logic [10:0] RST_SRC_W = 11'd320;
    localparam logic [10:0] RST_SRC_H = 11'd240;
    localparam logic [7:0]  RST_DST_W = 8'd96;
    localparam logic [7:0]  RST_DST_H = 8'd96;

    // BT.601 luma weights in Q0.16, summing to 65536
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } t_pixel;

    // Sampler verdict for the item at its input
    typedef struct packed {
        logic       hit;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } t_sample;

    typedef struct packed {
        logic signed [7:0] gray_value;
        logic [7:0]        out_column;
        logic [7:0]        out_row;
        logic              frame_last;
    } t_result;

    // Luma minus 128, truncated toward zero
    function automatic logic signed [7:0] gray_of(input logic [7:0] b,
                                                  input logic [7:0] g,
                                                  input logic [7:0] r);
        logic [23:0] sum;
        logic [7:0]  luma;
        logic        bump;
        sum  = 24'(W_RED * r) + 24'(W_GREEN * g) + 24'(W_BLUE * b);
        luma = sum[23:16];
        // below 128 with a fraction: truncation toward zero rounds up
        bump = !luma[7] && (sum[15:0] != 16'd0);
        return signed'({~luma[7], luma[6:0]} + {7'd0, bump});
    endfunction

endpackage

>>> hw/rtl/ndg_if.sv
// Handshake channels of the downscaler: pixel input, gray output and
// configuration writes. Depends on ndg_pkg for field widths.
interface ndg_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;

    modport source (output valid, blue, green, red, frame_start, input ready);
    modport sink   (input valid, blue, green, red, frame_start, output ready);
endinterface

interface ndg_gray_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] gray_value;
    logic [7:0]        out_column;
    logic [7:0]        out_row;
    logic              frame_last;

    modport source (output valid, gray_value, out_column, out_row, frame_last,
                    input ready);
    modport sink   (input valid, gray_value, out_column, out_row, frame_last,
                    output ready);
endinterface

interface ndg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ndg_pkg::CFG_ADDR_BITS-1:0] addr;
    logic [ndg_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> hw/rtl/ndg_div.sv
// Restoring divider, one quotient bit per cycle: source size over target size.
// Standalone; used by the downscaler top level for both axes.
module ndg_div #(
    parameter int COORD_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_dividend,
    input  logic [7:0]            i_divisor,
    output logic                  o_busy,
    output logic [COORD_BITS-1:0] o_quot,
    output logic [7:0]            o_rem
);

    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [COORD_BITS-1:0] r_dvd, n_dvd;
    logic [COORD_BITS-1:0] r_quot, n_quot;
    logic [7:0]            r_rem, n_rem;
    logic [7:0]            r_dsr, n_dsr;
    logic [8:0]            w_trial;
    logic [8:0]            w_diff;

    // One shift-subtract step
    always_comb begin
        w_trial = {r_rem, r_dvd[COORD_BITS-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        if (i_start) begin
            n_cnt  = CNT_W'(COORD_BITS);
            n_dvd  = i_dividend;
            n_quot = '0;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_dvd = r_dvd << 1;
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem  = w_diff[7:0];
                n_quot = {r_quot[COORD_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_trial[7:0];
                n_quot = {r_quot[COORD_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> hw/rtl/ndg_sampler.sv
// Source and destination position counters of the nearest-neighbor grid.
// Depends on ndg_pkg (t_sample).
module ndg_sampler #(
    parameter int COORD_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_frame_start,
    input  logic [COORD_BITS-1:0] i_src_w,
    input  logic [COORD_BITS-1:0] i_src_h,
    input  logic [7:0]            i_dst_w,
    input  logic [7:0]            i_dst_h,
    input  logic [COORD_BITS-1:0] i_col_quot,
    input  logic [7:0]            i_col_rem,
    input  logic [COORD_BITS-1:0] i_row_quot,
    input  logic [7:0]            i_row_rem,
    output ndg_pkg::t_sample      o_sample
);

    logic [COORD_BITS-1:0] r_src_col, n_src_col;
    logic [COORD_BITS-1:0] r_src_row, n_src_row;
    logic [COORD_BITS-1:0] r_nxt_col, n_nxt_col;
    logic [COORD_BITS-1:0] r_nxt_row, n_nxt_row;
    logic [7:0]            r_col_frac, n_col_frac;
    logic [7:0]            r_row_frac, n_row_frac;
    logic [7:0]            r_dst_col, n_dst_col;
    logic [7:0]            r_dst_row, n_dst_row;

    logic [COORD_BITS-1:0] w_src_col, w_src_row, w_nxt_col, w_nxt_row;
    logic [7:0]            w_col_frac, w_row_frac, w_dst_col, w_dst_row;
    logic                  w_row_hit, w_col_hit;
    logic [COORD_BITS-1:0] w_col_pos, w_row_pos;
    logic [8:0]            w_col_sum, w_row_sum;
    logic [COORD_BITS:0]   w_col_inc, w_row_inc;

    // Frame start clears every counter before the item is judged
    always_comb begin
        w_src_col  = i_frame_start ? '0 : r_src_col;
        w_src_row  = i_frame_start ? '0 : r_src_row;
        w_nxt_col  = i_frame_start ? '0 : r_nxt_col;
        w_nxt_row  = i_frame_start ? '0 : r_nxt_row;
        w_col_frac = i_frame_start ? '0 : r_col_frac;
        w_row_frac = i_frame_start ? '0 : r_row_frac;
        w_dst_col  = i_frame_start ? '0 : r_dst_col;
        w_dst_row  = i_frame_start ? '0 : r_dst_row;
    end

    // Judge the item against the grid
    always_comb begin
        w_row_hit     = (w_src_row == w_nxt_row) && (w_dst_row < i_dst_h);
        w_col_hit     = (w_src_col == w_nxt_col) && (w_dst_col < i_dst_w);
        o_sample.hit  = w_row_hit && w_col_hit;
        o_sample.col  = w_dst_col;
        o_sample.row  = w_dst_row;
        o_sample.last = (w_dst_col == i_dst_w - 8'd1) && (w_dst_row == i_dst_h - 8'd1);
    end

    // Next sampled positions: add quotient, carry the remainder
    always_comb begin
        w_col_sum = {1'b0, w_col_frac} + {1'b0, i_col_rem};
        w_col_pos = w_nxt_col + i_col_quot;
        if (w_col_sum >= {1'b0, i_dst_w}) begin
            w_col_sum = w_col_sum - {1'b0, i_dst_w};
            w_col_pos = w_col_pos + COORD_BITS'(1);
        end
        w_row_sum = {1'b0, w_row_frac} + {1'b0, i_row_rem};
        w_row_pos = w_nxt_row + i_row_quot;
        if (w_row_sum >= {1'b0, i_dst_h}) begin
            w_row_sum = w_row_sum - {1'b0, i_dst_h};
            w_row_pos = w_row_pos + COORD_BITS'(1);
        end
        w_col_inc = {1'b0, w_src_col} + (COORD_BITS + 1)'(1);
        w_row_inc = {1'b0, w_src_row} + (COORD_BITS + 1)'(1);
    end

    // Advance counters; end of line and end of frame wrap them
    always_comb begin
        n_src_col  = w_src_col;
        n_src_row  = w_src_row;
        n_nxt_col  = w_nxt_col;
        n_nxt_row  = w_nxt_row;
        n_col_frac = w_col_frac;
        n_row_frac = w_row_frac;
        n_dst_col  = w_dst_col;
        n_dst_row  = w_dst_row;
        if (w_col_hit) begin
            n_nxt_col  = w_col_pos;
            n_col_frac = w_col_sum[7:0];
            n_dst_col  = w_dst_col + 8'd1;
        end
        if (w_col_inc >= {1'b0, i_src_w}) begin
            n_src_col  = '0;
            n_nxt_col  = '0;
            n_col_frac = '0;
            n_dst_col  = '0;
            if (w_row_hit) begin
                n_nxt_row  = w_row_pos;
                n_row_frac = w_row_sum[7:0];
                n_dst_row  = w_dst_row + 8'd1;
            end
            if (w_row_inc >= {1'b0, i_src_h}) begin
                n_src_row  = '0;
                n_nxt_row  = '0;
                n_row_frac = '0;
                n_dst_row  = '0;
            end else begin
                n_src_row = w_row_inc[COORD_BITS-1:0];
            end
        end else begin
            n_src_col = w_col_inc[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_nxt_col  <= '0;
            r_nxt_row  <= '0;
            r_col_frac <= '0;
            r_row_frac <= '0;
            r_dst_col  <= '0;
            r_dst_row  <= '0;
        end else if (i_step) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_nxt_col  <= n_nxt_col;
            r_nxt_row  <= n_nxt_row;
            r_col_frac <= n_col_frac;
            r_row_frac <= n_row_frac;
            r_dst_col  <= n_dst_col;
            r_dst_row  <= n_dst_row;
        end
    end

endmodule

>>> hw/rtl/nearest_downscale_gray_int8_core.sv
// Input and result registers; one pixel per cycle unless dividers busy or output full.
// A pixel off the sampling grid is consumed and gives no result.
// Ratio dividers rerun after reset and after each
// configuration write; the pixel input is not ready during that time.
// Reset (synchronous, active low) clears counters and loads default sizes.
// Depends on ndg_pkg, ndg_if, ndg_div and ndg_sampler.
module nearest_downscale_gray_int8_core #(
    parameter int COORD_BITS = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ndg_pix_if.sink           i_pix,
    ndg_gray_if.source        o_gray,
    ndg_cfg_if.sink           i_cfg
);

    // Configuration registers
    logic [10:0] r_src_w, r_src_h;
    logic [7:0]  r_dst_w, r_dst_h;
    logic        r_div_start;

    // Input and result registers
    logic              r_s1_valid;
    ndg_pkg::t_pixel   r_s1_pix;
    logic              r_out_valid;
    ndg_pkg::t_result  r_out;

    logic [COORD_BITS-1:0] w_sw, w_sh, w_sw_raw, w_sh_raw;
    logic [7:0]            w_tw, w_th, w_tw_raw, w_th_raw;
    logic [COORD_BITS-1:0] w_col_quot, w_row_quot;
    logic [7:0]            w_col_rem, w_row_rem;
    logic                  w_col_busy, w_row_busy, w_div_busy;
    logic                  w_out_free, w_s1_fire, w_in_fire;
    ndg_pkg::t_sample      w_sample;

    // Take register writes; any write restarts the ratio dividers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= ndg_pkg::RST_SRC_W;
            r_src_h     <= ndg_pkg::RST_SRC_H;
            r_dst_w     <= ndg_pkg::RST_DST_W;
            r_dst_h     <= ndg_pkg::RST_DST_H;
            r_div_start <= 1'b1;
        end else begin
            r_div_start <= i_cfg.valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.addr)
                    ndg_pkg::CFG_SRC_W: r_src_w <= i_cfg.data;
                    ndg_pkg::CFG_SRC_H: r_src_h <= i_cfg.data;
                    ndg_pkg::CFG_DST_W: r_dst_w <= i_cfg.data[7:0];
                    ndg_pkg::CFG_DST_H: r_dst_h <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Effective sizes: zero counts as one, target clamped to source
    always_comb begin
        w_sw_raw = COORD_BITS'(r_src_w);
        w_sh_raw = COORD_BITS'(r_src_h);
        w_sw     = (w_sw_raw == '0) ? COORD_BITS'(1) : w_sw_raw;
        w_sh     = (w_sh_raw == '0) ? COORD_BITS'(1) : w_sh_raw;
        w_tw_raw = (r_dst_w == 8'd0) ? 8'd1 : r_dst_w;
        w_th_raw = (r_dst_h == 8'd0) ? 8'd1 : r_dst_h;
        w_tw     = (COORD_BITS'(w_tw_raw) > w_sw) ? w_sw[7:0] : w_tw_raw;
        w_th     = (COORD_BITS'(w_th_raw) > w_sh) ? w_sh[7:0] : w_th_raw;
    end

    ndg_div #(.COORD_BITS(COORD_BITS)) u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_sw),
        .i_divisor  (w_tw),
        .o_busy     (w_col_busy),
        .o_quot     (w_col_quot),
        .o_rem      (w_col_rem)
    );

    ndg_div #(.COORD_BITS(COORD_BITS)) u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_sh),
        .i_divisor  (w_th),
        .o_busy     (w_row_busy),
        .o_quot     (w_row_quot),
        .o_rem      (w_row_rem)
    );

    assign w_div_busy = r_div_start || w_col_busy || w_row_busy;

    ndg_sampler #(.COORD_BITS(COORD_BITS)) u_sampler (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_s1_fire),
        .i_frame_start (r_s1_pix.frame_start),
        .i_src_w       (w_sw),
        .i_src_h       (w_sh),
        .i_dst_w       (w_tw),
        .i_dst_h       (w_th),
        .i_col_quot    (w_col_quot),
        .i_col_rem     (w_col_rem),
        .i_row_quot    (w_row_quot),
        .i_row_rem     (w_row_rem),
        .o_sample      (w_sample)
    );

    // Handshake: retire an item unless the dividers are busy or its result finds the output full
    assign w_out_free  = !r_out_valid || o_gray.ready;
    assign w_s1_fire   = r_s1_valid && !w_div_busy && (!w_sample.hit || w_out_free);
    assign i_pix.ready = !w_div_busy && (!r_s1_valid || w_s1_fire);
    assign w_in_fire   = i_pix.valid && i_pix.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_fire) begin
            r_s1_pix.blue        <= i_pix.blue;
            r_s1_pix.green       <= i_pix.green;
            r_s1_pix.red         <= i_pix.red;
            r_s1_pix.frame_start <= i_pix.frame_start;
        end
    end

    // Result register: load on a hit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && w_sample.hit) begin
            r_out_valid <= 1'b1;
        end else if (o_gray.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_fire && w_sample.hit) begin
            r_out.gray_value <= ndg_pkg::gray_of(r_s1_pix.blue, r_s1_pix.green,
                                                 r_s1_pix.red);
            r_out.out_column <= w_sample.col;
            r_out.out_row    <= w_sample.row;
            r_out.frame_last <= w_sample.last;
        end
    end

    assign o_gray.valid      = r_out_valid;
    assign o_gray.gray_value = r_out.gray_value;
    assign o_gray.out_column = r_out.out_column;
    assign o_gray.out_row    = r_out.out_row;
    assign o_gray.frame_last = r_out.frame_last;

    // No pixel is taken while the ratios are being computed
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !i_pix.ready)
        else $error("pixel accepted while dividers busy");

    // A sampled item always lands in the result register
    a_hit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && w_sample.hit) |=> r_out_valid)
        else $error("sampled item lost");

    // Destination positions stay inside the target grid
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.out_column < w_tw) && (r_out.out_row < w_th))
        else $error("destination position outside target grid");

    // The last flag marks the bottom-right destination pixel only
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_last) |->
            (r_out.out_column == w_tw - 8'd1) && (r_out.out_row == w_th - 8'd1))
        else $error("frame_last on wrong position");

endmodule

>>> test/tb.sv
// Testbench for nearest_downscale_gray_int8_core: streams pixel frames under
// many size settings, predicts every gray item and checks them in order.
// Depends on ndg_pkg, the ndg handshake interfaces and the core RTL.
`timescale 1ns / 100ps

// Follow the sampling grid and queue the gray items the core must produce
class gray_tracker;
    ndg_pkg::t_result pending_grays[$];
    int               error_count;
    logic [10:0]      src_w, src_h;
    logic [7:0]       dst_w, dst_h;
    logic [10:0]      src_col, src_row, pick_col, pick_row;
    logic [7:0]       col_frac, row_frac, dst_col, dst_row;

    function new();
        error_count = 0;
        src_w = ndg_pkg::RST_SRC_W;
        src_h = ndg_pkg::RST_SRC_H;
        dst_w = ndg_pkg::RST_DST_W;
        dst_h = ndg_pkg::RST_DST_H;
        clear_cols();
        clear_rows();
    endfunction

    function void clear_cols();
        src_col  = '0;
        pick_col = '0;
        col_frac = '0;
        dst_col  = '0;
    endfunction

    function void clear_rows();
        src_row  = '0;
        pick_row = '0;
        row_frac = '0;
        dst_row  = '0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [10:0] value);
        case (idx)
            ndg_pkg::CFG_SRC_W: src_w = value;
            ndg_pkg::CFG_SRC_H: src_h = value;
            ndg_pkg::CFG_DST_W: dst_w = value[7:0];
            ndg_pkg::CFG_DST_H: dst_h = value[7:0];
            default: ;
        endcase
    endfunction

    // Step a sampler by src/dst as whole part plus carried remainder
    function void step_sampler(inout logic [10:0] pos, inout logic [7:0] frac,
                               input int src, input int dst);
        int p, m;
        p = pos + src / dst;
        m = frac + src % dst;
        if (m >= dst) begin
            m = m - dst;
            p = p + 1;
        end
        pos  = p[10:0];
        frac = m[7:0];
    endfunction

    // BT.601 luma in Q16, minus 128, truncated toward zero
    function logic signed [7:0] luma_offset(logic [7:0] b, logic [7:0] g,
                                            logic [7:0] r);
        int sum, diff, v;
        sum  = 19595 * r + 38470 * g + 7471 * b;
        diff = sum - 128 * 65536;
        v    = (diff >= 0) ? diff / 65536 : -((-diff) / 65536);
        return v[7:0];
    endfunction

    function void take_pixel(ndg_pkg::t_pixel px);
        int               sw, sh, tw, th;
        bit               row_hit, col_hit;
        ndg_pkg::t_result res;
        // zero sizes count as one, targets clamp to the source size
        sw = (src_w == 0) ? 1 : src_w;
        sh = (src_h == 0) ? 1 : src_h;
        tw = (dst_w == 0) ? 1 : dst_w;
        th = (dst_h == 0) ? 1 : dst_h;
        if (tw > sw) tw = sw;
        if (th > sh) th = sh;
        if (px.frame_start) begin
            clear_cols();
            clear_rows();
        end
        row_hit = (src_row == pick_row) && (dst_row < th);
        col_hit = (src_col == pick_col) && (dst_col < tw);
        if (row_hit && col_hit) begin
            res.gray_value = luma_offset(px.blue, px.green, px.red);
            res.out_column = dst_col;
            res.out_row    = dst_row;
            res.frame_last = (dst_col == tw - 1) && (dst_row == th - 1);
            pending_grays.push_back(res);
        end
        if (col_hit) begin
            step_sampler(pick_col, col_frac, sw, tw);
            dst_col = dst_col + 8'd1;
        end
        // wrap the line, and the frame after its last line
        if (src_col + 1 >= sw) begin
            clear_cols();
            if (row_hit) begin
                step_sampler(pick_row, row_frac, sh, th);
                dst_row = dst_row + 8'd1;
            end
            if (src_row + 1 >= sh)
                clear_rows();
            else
                src_row = src_row + 11'd1;
        end else begin
            src_col = src_col + 11'd1;
        end
    endfunction

    function void match_gray(ndg_pkg::t_result got);
        ndg_pkg::t_result want;
        if (pending_grays.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected gray item: value %0d col %0d row %0d last %0d",
                         got.gray_value, got.out_column, got.out_row, got.frame_last);
            return;
        end
        want = pending_grays.pop_front();
        if (got.gray_value !== want.gray_value || got.out_column !== want.out_column ||
            got.out_row !== want.out_row || got.frame_last !== want.frame_last) begin
            error_count++;
            if (error_count <= 10)
                $display({"gray item mismatch (value/col/row/last): ",
                          "expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d"},
                         want.gray_value, want.out_column, want.out_row,
                         want.frame_last, got.gray_value, got.out_column,
                         got.out_row, got.frame_last);
        end
    endfunction
endclass

module tb;

    localparam logic [3:0] CFG_UNUSED  = 4'hF;
    localparam int         CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   pixels_sent;
    int   cycle_count;

    gray_tracker tracker = new();

    ndg_pix_if  pix_ch();
    ndg_gray_if gray_ch();
    ndg_cfg_if  cfg_ch();

    nearest_downscale_gray_int8_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_gray  (gray_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hold off the gray output at random, never inside the steady stretch
    initial begin
        gray_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            gray_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge i_clk) begin : take_gray
        ndg_pkg::t_result got;
        if (i_rst_n && gray_ch.valid && gray_ch.ready) begin
            got.gray_value = gray_ch.gray_value;
            got.out_column = gray_ch.out_column;
            got.out_row    = gray_ch.out_row;
            got.frame_last = gray_ch.frame_last;
            tracker.match_gray(got);
        end
    end

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic ndg_pkg::t_pixel make_pixel(int b, int g, int r, bit start);
        ndg_pkg::t_pixel px;
        px.blue        = b[7:0];
        px.green       = g[7:0];
        px.red         = r[7:0];
        px.frame_start = start;
        return px;
    endfunction

    // Random color, with the component extremes now and then
    function automatic ndg_pkg::t_pixel random_pixel(bit start);
        int c[3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 9))
                0: c[k] = 0;
                1: c[k] = 255;
                default: c[k] = $urandom_range(0, 255);
            endcase
        end
        return make_pixel(c[0], c[1], c[2], start);
    endfunction

    // Offer one pixel after random idle cycles; return at the next falling edge
    task automatic send_pixel(input ndg_pkg::t_pixel px);
        while (!steady && $urandom_range(0, 99) < 19) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.blue        <= px.blue;
        pix_ch.green       <= px.green;
        pix_ch.red         <= px.red;
        pix_ch.frame_start <= px.frame_start;
        do @(posedge i_clk); while (!pix_ch.ready);
        tracker.take_pixel(px);
        pixels_sent++;
        steady = (pixels_sent >= 300) && (pixels_sent < 500);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [10:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    // Drop the pixel valid and wait until every gray item is out
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (tracker.pending_grays.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic configure(input logic [10:0] sw, input logic [10:0] sh,
                             input logic [10:0] tw, input logic [10:0] th);
        settle();
        write_reg(ndg_pkg::CFG_SRC_W, sw);
        write_reg(ndg_pkg::CFG_SRC_H, sh);
        write_reg(ndg_pkg::CFG_DST_W, tw);
        write_reg(ndg_pkg::CFG_DST_H, th);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 11'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int random_sent;
        int phase;
        int sw, sh, esw, esh, tw, th, count, frames;
        bit omit;

        i_rst_n            <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.blue        <= '0;
        pix_ch.green       <= '0;
        pix_ch.red         <= '0;
        pix_ch.frame_start <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.addr        <= '0;
        cfg_ch.data        <= '0;
        pixels_sent = 0;
        steady      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset sizes: start of a 320x240 frame sampled down to 96x96
        send_pixel(make_pixel(0, 0, 0, 1'b1));
        for (int k = 0; k < 3; k++) send_pixel(random_pixel(1'b0));

        // 3x2 source, target width above source, target height zero
        configure(11'd3, 11'd2, 11'h105, 11'd0);
        send_pixel(make_pixel(0, 0, 0, 1'b1));
        send_pixel(make_pixel(255, 255, 255, 1'b0));
        send_pixel(make_pixel(128, 128, 128, 1'b0));
        send_pixel(make_pixel(10, 20, 30, 1'b0));
        send_pixel(make_pixel(40, 50, 60, 1'b0));
        send_pixel(make_pixel(70, 80, 90, 1'b0));
        // frame wraps without a frame start
        send_pixel(make_pixel(127, 127, 127, 1'b0));
        send_pixel(make_pixel(0, 0, 255, 1'b0));

        // Change sizes in the middle of a line and keep streaming
        configure(11'd4, 11'd3, 11'd2, 11'd3);
        for (int k = 0; k < 10; k++) send_pixel(random_pixel(1'b0));

        // Random phases, a few at the size extremes
        random_sent = 0;
        phase       = 0;
        while (random_sent < 420 || phase < 10) begin
            case (phase)
                2: begin
                    // start of the widest line at the full target width
                    configure(11'd2047, 11'd1, {3'b111, 8'd255}, {3'b101, 8'd255});
                    for (int k = 0; k < 120; k++) send_pixel(random_pixel(k == 0));
                end
                6: begin
                    // top of the tallest frame, one column
                    configure(11'd1, 11'd2047, {3'b010, 8'd255}, 11'd255);
                    for (int k = 0; k < 120; k++) send_pixel(random_pixel(k == 0));
                end
                9: begin
                    // all sizes zero: one-pixel frames
                    configure(11'd0, 11'd0, 11'd0, 11'd0);
                    for (int k = 0; k < 8; k++)
                        send_pixel(random_pixel($urandom_range(0, 1) == 1));
                end
                default: begin
                    sw  = $urandom_range(0, 12);
                    sh  = $urandom_range(0, 8);
                    esw = (sw == 0) ? 1 : sw;
                    esh = (sh == 0) ? 1 : sh;
                    tw  = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, esw + 3);
                    th  = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, esh + 3);
                    configure(11'(sw), 11'(sh),
                              {3'($urandom_range(0, 7)), 8'(tw)},
                              {3'($urandom_range(0, 7)), 8'(th)});
                    if ($urandom_range(0, 4) == 0) begin
                        // broken stream: stray frame starts, partial frames
                        count = $urandom_range(1, 2 * esw * esh + 3);
                        for (int k = 0; k < count; k++)
                            send_pixel(random_pixel($urandom_range(0, 7) == 0));
                        random_sent += count;
                    end else begin
                        frames = $urandom_range(1, 3);
                        for (int f = 0; f < frames; f++) begin
                            omit = ($urandom_range(0, 5) == 0);
                            for (int k = 0; k < esw * esh; k++)
                                send_pixel(random_pixel((k == 0) && !omit));
                            random_sent += esw * esh;
                        end
                    end
                end
            endcase
            phase++;
        end

        settle();
        if (tracker.error_count == 0 && tracker.pending_grays.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ndg_pkg.sv
hw/rtl/ndg_if.sv
hw/rtl/ndg_div.sv
hw/rtl/ndg_sampler.sv
hw/rtl/nearest_downscale_gray_int8_core.sv
test/tb.sv
